### sv/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared widths, reset values, request kinds and result status codes.
// ----------------------------------------------------------------------------
package stq_pkg;

  // Default pool configuration
  localparam int SLOT_COUNT_DEF   = 8;
  localparam int HANDLER_BITS_DEF = 8;

  // Most timers fired by one process request
  localparam int MAX_FIRE = 8;

  // Field widths
  localparam int KIND_W    = 2;
  localparam int TIME_W    = 32;
  localparam int HANDLER_W = 8;
  localparam int ARG_W     = 16;
  localparam int SLOT_W    = 3;
  localparam int STATUS_W  = 3;
  localparam int TPS_W     = 17;

  // Tick rate register reset value
  localparam logic [TPS_W-1:0] TPS_RESET = 17'd32768;

  // Millisecond to tick conversion: product, then a division by 1000
  localparam int MS_PER_SECOND = 1000;
  localparam int PROD_W        = TIME_W + TPS_W;
  localparam int REM_W         = 10;
  localparam int DIV_BITS      = 7;
  localparam int DIV_CYCLES    = PROD_W / DIV_BITS;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PROCESS = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_SET_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STS_POOL_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] STS_CANCELLED = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_ARMED = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FIRED     = 3'd4;
  localparam logic [STATUS_W-1:0] STS_NOTHING   = 3'd5;

endpackage

### sv/stq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stq_ram import stq_pkg::*; #(
  parameter int WIDTH = TIME_W,
  parameter int DEPTH = SLOT_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/sorted_timer_queue_top.sv
// ----------------------------------------------------------------------------
// Sorted timer queue
// Timer slot pool with a free stack and an armed list sorted by expiry tick.
// ----------------------------------------------------------------------------
// Usage: a request word is taken on a clock edge where start is high and busy
// is low. in_kind selects set (arm a timer interval_ms from now), cancel (by
// slot number) or process (fire every armed timer at or below now). Each
// result word is shown for one cycle with out_valid high; the receiver cannot
// stall, so every result is delivered on the cycle it appears. out_last marks
// the final result of a request. A process request fires up to MAX_FIRE
// timers, one result per cycle.
// Pool full, and cancel or process on an empty list, are answered straight
// from idle. A set runs the multiplier step and the 7-bit-per-cycle
// divide-by-1000 unit, stores the slot, then walks one list step per cycle
// through the registered link memory past each armed entry that precedes
// the new one and links it in. Cancel walks to the slot and unlinks it;
// process examines entries from the head. busy is high outside idle.
// Reset: synchronous, active low. The free stack holds every slot in order,
// the armed list is empty and ticks_per_second returns to 32768. No memory
// clearing pass is needed; untouched slots are tracked by a fill count.
// cfg_we writes ticks_per_second and must only be used while idle.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top import stq_pkg::*; #(
  parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
  parameter int HANDLER_BITS = HANDLER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [TIME_W-1:0]    in_now,
  input  logic [TIME_W-1:0]    in_interval_ms,
  input  logic [HANDLER_W-1:0] in_handler_id,
  input  logic [ARG_W-1:0]     in_argument,
  input  logic [SLOT_W-1:0]    in_slot,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [SLOT_W-1:0]    out_slot_number,
  output logic [HANDLER_W-1:0] out_fired_handler,
  output logic [ARG_W-1:0]     out_fired_argument,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [TPS_W-1:0]     cfg_wdata
);

  localparam int AW     = $clog2(SLOT_COUNT);
  localparam int IW     = $clog2(SLOT_COUNT + 1);
  localparam int CNT_W  = $clog2(MAX_FIRE + 1);
  localparam int DCW    = $clog2(DIV_CYCLES);
  localparam int DATA_W = TIME_W + HANDLER_W + ARG_W;

  localparam logic [IW-1:0] NIL       = IW'(SLOT_COUNT);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);
  localparam logic [HANDLER_W-1:0] HMASK = (HANDLER_BITS >= HANDLER_W) ?
      {HANDLER_W{1'b1}} : HANDLER_W'((1 << HANDLER_BITS) - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MUL   = 11'b000_0000_0010,
    S_DIV   = 11'b000_0000_0100,
    S_WSTRT = 11'b000_0000_1000,
    S_WALK  = 11'b000_0001_0000,
    S_INS   = 11'b000_0010_0000,
    S_FIX   = 11'b000_0100_0000,
    S_CWALK = 11'b000_1000_0000,
    S_CPUSH = 11'b001_0000_0000,
    S_PWALK = 11'b010_0000_0000,
    S_PDONE = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // List heads, fill count of never-used slots and walk pointers
  logic [IW-1:0] armed_head_r, armed_head_nxt;
  logic [IW-1:0] free_head_r, free_head_nxt;
  logic [IW-1:0] fresh_r, fresh_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] new_slot_r, new_slot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Expiry arithmetic
  logic [TPS_W-1:0]  tps_r;
  logic [DCW-1:0]    div_cnt_r, div_cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [TIME_W-1:0] exp_r, exp_nxt;
  logic [TIME_W-1:0] exp_sum;
  logic [PROD_W-1:0] div_prod;
  logic [REM_W-1:0]  div_rem;
  logic [TIME_W-1:0] div_quo;

  // Request word held for the duration of the request
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [TIME_W-1:0]    interval_r, interval_nxt;
  logic [HANDLER_W-1:0] handler_r, handler_nxt;
  logic [ARG_W-1:0]     arg_r, arg_nxt;
  logic [SLOT_W-1:0]    want_r, want_nxt;

  // Fired timer held back until it is known whether it is the final one
  logic [IW-1:0]        pend_slot_r, pend_slot_nxt;
  logic [HANDLER_W-1:0] pend_handler_r, pend_handler_nxt;
  logic [ARG_W-1:0]     pend_arg_r, pend_arg_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [HANDLER_W-1:0] out_handler_r, out_handler_nxt;
  logic [ARG_W-1:0]     out_arg_r, out_arg_nxt;
  logic                 out_last_r, out_last_nxt;

  // Memory ports
  logic              d_we;
  logic [AW-1:0]     d_waddr;
  logic [DATA_W-1:0] d_wdata;
  logic [DATA_W-1:0] d_rdata;
  logic              l_we;
  logic [AW-1:0]     l_waddr;
  logic [IW-1:0]     l_wdata;
  logic [IW-1:0]     l_rdata;
  logic [AW-1:0]     rd_addr;

  logic [TIME_W-1:0]    rd_exp;
  logic [HANDLER_W-1:0] rd_handler;
  logic [ARG_W-1:0]     rd_arg;

  // Slot data memory: expiry, handler and argument.
  stq_ram #(.WIDTH(DATA_W), .DEPTH(SLOT_COUNT)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (rd_addr),
    .rdata (d_rdata)
  );

  // Link memory shared by the free stack and the armed list.
  stq_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (rd_addr),
    .rdata (l_rdata)
  );

  assign rd_exp     = d_rdata[DATA_W-1 -: TIME_W];
  assign rd_handler = d_rdata[ARG_W +: HANDLER_W];
  assign rd_arg     = d_rdata[ARG_W-1:0];
  assign exp_sum    = now_r + quo_r;

  // Divide-by-1000 step: several restoring steps on the narrow remainder.
  always_comb begin : div_step
    logic [REM_W:0] trial;
    div_prod = prod_r;
    div_rem  = rem_r;
    div_quo  = quo_r;
    for (int j = 0; j < DIV_BITS; j++) begin
      trial    = {div_rem, div_prod[PROD_W-1]};
      div_prod = {div_prod[PROD_W-2:0], 1'b0};
      if (trial >= (REM_W + 1)'(MS_PER_SECOND)) begin
        div_rem = REM_W'(trial - (REM_W + 1)'(MS_PER_SECOND));
        div_quo = {div_quo[TIME_W-2:0], 1'b1};
      end else begin
        div_rem = REM_W'(trial);
        div_quo = {div_quo[TIME_W-2:0], 1'b0};
      end
    end
  end

  // Sequencer: list walks, memory writes and result words.
  always_comb begin
    state_nxt        = state_r;
    armed_head_nxt   = armed_head_r;
    free_head_nxt    = free_head_r;
    fresh_nxt        = fresh_r;
    cur_nxt          = cur_r;
    prev_nxt         = prev_r;
    new_slot_nxt     = new_slot_r;
    cnt_nxt          = cnt_r;
    div_cnt_nxt      = div_cnt_r;
    prod_nxt         = prod_r;
    rem_nxt          = rem_r;
    quo_nxt          = quo_r;
    exp_nxt          = exp_r;
    now_nxt          = now_r;
    interval_nxt     = interval_r;
    handler_nxt      = handler_r;
    arg_nxt          = arg_r;
    want_nxt         = want_r;
    pend_slot_nxt    = pend_slot_r;
    pend_handler_nxt = pend_handler_r;
    pend_arg_nxt     = pend_arg_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = out_status_r;
    out_slot_nxt     = out_slot_r;
    out_handler_nxt  = out_handler_r;
    out_arg_nxt      = out_arg_r;
    out_last_nxt     = out_last_r;
    d_we             = 1'b0;
    d_waddr          = new_slot_r[AW-1:0];
    d_wdata          = {exp_sum, handler_r, arg_r};
    l_we             = 1'b0;
    l_waddr          = cur_r[AW-1:0];
    l_wdata          = free_head_r;
    rd_addr          = armed_head_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          now_nxt      = in_now;
          interval_nxt = in_interval_ms;
          handler_nxt  = in_handler_id & HMASK;
          arg_nxt      = in_argument;
          want_nxt     = in_slot;
          cur_nxt      = armed_head_r;
          prev_nxt     = NIL;
          cnt_nxt      = '0;
          if (in_kind == KIND_SET) begin
            if (free_head_r == NIL) begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = STS_POOL_FULL;
              out_slot_nxt    = '0;
              out_handler_nxt = '0;
              out_arg_nxt     = '0;
              out_last_nxt    = 1'b1;
            end else begin
              new_slot_nxt = free_head_r;
              state_nxt    = S_MUL;
            end
          end else if (in_kind == KIND_CANCEL) begin
            if (armed_head_r == NIL) begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = STS_NOT_ARMED;
              out_slot_nxt    = in_slot;
              out_handler_nxt = '0;
              out_arg_nxt     = '0;
              out_last_nxt    = 1'b1;
            end else begin
              state_nxt = S_CWALK;
            end
          end else if (in_kind == KIND_PROCESS) begin
            if (armed_head_r == NIL) begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = STS_NOTHING;
              out_slot_nxt    = '0;
              out_handler_nxt = '0;
              out_arg_nxt     = '0;
              out_last_nxt    = 1'b1;
            end else begin
              state_nxt = S_PWALK;
            end
          end
        end
      end

      // Tick delta product; fetch the link of the slot being taken.
      S_MUL: begin
        prod_nxt    = PROD_W'(interval_r) * PROD_W'(tps_r);
        rem_nxt     = '0;
        quo_nxt     = '0;
        div_cnt_nxt = '0;
        rd_addr     = free_head_r[AW-1:0];
        state_nxt   = S_DIV;
      end

      // Divide by 1000; pop the free stack on the first divide cycle.
      S_DIV: begin
        prod_nxt = div_prod;
        rem_nxt  = div_rem;
        quo_nxt  = div_quo;
        if (div_cnt_r == '0) begin
          // A slot never used before links to the next unused slot.
          if (free_head_r == fresh_r) begin
            fresh_nxt     = fresh_r + IW'(1);
            free_head_nxt = (fresh_r == LAST_SLOT) ? NIL : fresh_r + IW'(1);
          end else begin
            free_head_nxt = l_rdata;
          end
        end
        if (div_cnt_r == DCW'(DIV_CYCLES - 1)) begin
          state_nxt = S_WSTRT;
        end else begin
          div_cnt_nxt = div_cnt_r + DCW'(1);
        end
      end

      // Store the new slot and start the walk at the armed head.
      S_WSTRT: begin
        exp_nxt  = exp_sum;
        d_we     = 1'b1;
        cur_nxt  = armed_head_r;
        prev_nxt = NIL;
        state_nxt = (armed_head_r == NIL) ? S_INS : S_WALK;
      end

      // Skip entries whose expiry is at or below the new one.
      S_WALK: begin
        if (rd_exp > exp_r) begin
          state_nxt = S_INS;
        end else begin
          prev_nxt = cur_r;
          if (l_rdata == NIL) begin
            cur_nxt   = NIL;
            state_nxt = S_INS;
          end else begin
            cur_nxt = l_rdata;
            rd_addr = l_rdata[AW-1:0];
          end
        end
      end

      // Link the new slot in front of the stopping entry.
      S_INS: begin
        l_we    = 1'b1;
        l_waddr = new_slot_r[AW-1:0];
        l_wdata = cur_r;
        if (prev_r == NIL) begin
          armed_head_nxt  = new_slot_r;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STS_SET_OK;
          out_slot_nxt    = SLOT_W'(new_slot_r);
          out_handler_nxt = '0;
          out_arg_nxt     = '0;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_FIX;
        end
      end

      // Point the predecessor at the new slot.
      S_FIX: begin
        l_we            = 1'b1;
        l_waddr         = prev_r[AW-1:0];
        l_wdata         = new_slot_r;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = STS_SET_OK;
        out_slot_nxt    = SLOT_W'(new_slot_r);
        out_handler_nxt = '0;
        out_arg_nxt     = '0;
        out_last_nxt    = 1'b1;
        state_nxt       = S_IDLE;
      end

      // Search the armed list for the slot to cancel.
      S_CWALK: begin
        if (32'(cur_r) == 32'(want_r)) begin
          if (prev_r == NIL) begin
            armed_head_nxt  = l_rdata;
            l_we            = 1'b1;
            free_head_nxt   = cur_r;
            out_valid_nxt   = 1'b1;
            out_status_nxt  = STS_CANCELLED;
            out_slot_nxt    = SLOT_W'(cur_r);
            out_handler_nxt = '0;
            out_arg_nxt     = '0;
            out_last_nxt    = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            l_we      = 1'b1;
            l_waddr   = prev_r[AW-1:0];
            l_wdata   = l_rdata;
            state_nxt = S_CPUSH;
          end
        end else begin
          prev_nxt = cur_r;
          if (l_rdata == NIL) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = STS_NOT_ARMED;
            out_slot_nxt    = want_r;
            out_handler_nxt = '0;
            out_arg_nxt     = '0;
            out_last_nxt    = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cur_nxt = l_rdata;
            rd_addr = l_rdata[AW-1:0];
          end
        end
      end

      // Push the cancelled slot on the free stack.
      S_CPUSH: begin
        l_we            = 1'b1;
        free_head_nxt   = cur_r;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = STS_CANCELLED;
        out_slot_nxt    = SLOT_W'(cur_r);
        out_handler_nxt = '0;
        out_arg_nxt     = '0;
        out_last_nxt    = 1'b1;
        state_nxt       = S_IDLE;
      end

      // Fire expired entries from the head; the previous one goes out now.
      S_PWALK: begin
        if (now_r >= rd_exp) begin
          if (cnt_r != '0) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = STS_FIRED;
            out_slot_nxt    = SLOT_W'(pend_slot_r);
            out_handler_nxt = pend_handler_r;
            out_arg_nxt     = pend_arg_r;
            out_last_nxt    = 1'b0;
          end
          pend_slot_nxt    = cur_r;
          pend_handler_nxt = rd_handler;
          pend_arg_nxt     = rd_arg;
          cnt_nxt          = cnt_r + CNT_W'(1);
          armed_head_nxt   = l_rdata;
          l_we             = 1'b1;
          free_head_nxt    = cur_r;
          if (l_rdata == NIL || cnt_r == CNT_W'(MAX_FIRE - 1)) begin
            state_nxt = S_PDONE;
          end else begin
            cur_nxt = l_rdata;
            rd_addr = l_rdata[AW-1:0];
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (cnt_r != '0) begin
            out_status_nxt  = STS_FIRED;
            out_slot_nxt    = SLOT_W'(pend_slot_r);
            out_handler_nxt = pend_handler_r;
            out_arg_nxt     = pend_arg_r;
          end else begin
            out_status_nxt  = STS_NOTHING;
            out_slot_nxt    = '0;
            out_handler_nxt = '0;
            out_arg_nxt     = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      // Final fired timer of the request.
      S_PDONE: begin
        out_valid_nxt   = 1'b1;
        out_status_nxt  = STS_FIRED;
        out_slot_nxt    = SLOT_W'(pend_slot_r);
        out_handler_nxt = pend_handler_r;
        out_arg_nxt     = pend_arg_r;
        out_last_nxt    = 1'b1;
        state_nxt       = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      armed_head_r <= NIL;
      free_head_r  <= '0;
      fresh_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      armed_head_r <= armed_head_nxt;
      free_head_r  <= free_head_nxt;
      fresh_r      <= fresh_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Tick rate register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cur_r          <= cur_nxt;
    prev_r         <= prev_nxt;
    new_slot_r     <= new_slot_nxt;
    cnt_r          <= cnt_nxt;
    div_cnt_r      <= div_cnt_nxt;
    prod_r         <= prod_nxt;
    rem_r          <= rem_nxt;
    quo_r          <= quo_nxt;
    exp_r          <= exp_nxt;
    now_r          <= now_nxt;
    interval_r     <= interval_nxt;
    handler_r      <= handler_nxt;
    arg_r          <= arg_nxt;
    want_r         <= want_nxt;
    pend_slot_r    <= pend_slot_nxt;
    pend_handler_r <= pend_handler_nxt;
    pend_arg_r     <= pend_arg_nxt;
    out_status_r   <= out_status_nxt;
    out_slot_r     <= out_slot_nxt;
    out_handler_r  <= out_handler_nxt;
    out_arg_r      <= out_arg_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_number    = out_slot_r;
  assign out_fired_handler  = out_handler_r;
  assign out_fired_argument = out_arg_r;
  assign out_last           = out_last_r;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Drives set, cancel and process request words into the timer queue, first
// from a short directed table and then at random, under several tick rates.
// A model of the slot pool kept here predicts every result word, and each
// word the block shows is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import stq_pkg::*;

  localparam int POOL           = SLOT_COUNT_DEF;
  localparam logic [3:0] NIL    = 4'(POOL);
  localparam int DIR_ROWS       = 24;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 57;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 40;

  // One request word, with an optional hand-written expected result
  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [TIME_W-1:0]    now;
    logic [TIME_W-1:0]    interval_ms;
    logic [HANDLER_W-1:0] handler_id;
    logic [ARG_W-1:0]     argument;
    logic [SLOT_W-1:0]    slot;
    bit                   typed;
    logic [STATUS_W-1:0]  t_status;
    logic [SLOT_W-1:0]    t_slot;
  } timer_word_t;

  // One result word
  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot_number;
    logic [HANDLER_W-1:0] fired_handler;
    logic [ARG_W-1:0]     fired_argument;
    logic                 last;
  } timer_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [KIND_W-1:0]    in_kind;
  logic [TIME_W-1:0]    in_now;
  logic [TIME_W-1:0]    in_interval_ms;
  logic [HANDLER_W-1:0] in_handler_id;
  logic [ARG_W-1:0]     in_argument;
  logic [SLOT_W-1:0]    in_slot;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [SLOT_W-1:0]    out_slot_number;
  logic [HANDLER_W-1:0] out_fired_handler;
  logic [ARG_W-1:0]     out_fired_argument;
  logic                 out_last;
  logic                 cfg_we;
  logic [TPS_W-1:0]     cfg_wdata;

  // Hand-written expectation that travels with the word on the input port
  bit                   typed_pending;
  logic [STATUS_W-1:0]  typed_status;
  logic [SLOT_W-1:0]    typed_slot;

  // Shadow copy of the slot pool
  logic [TPS_W-1:0]     tick_rate;
  logic [TIME_W-1:0]    expiry_tick [POOL];
  logic [HANDLER_W-1:0] slot_handler [POOL];
  logic [ARG_W-1:0]     slot_argument [POOL];
  logic [3:0]           slot_link [POOL];
  logic [3:0]           armed_top;
  logic [3:0]           free_top;

  timer_result_t        pending_results [$];
  int                   mismatches;
  int                   quiet_cycles;

  sorted_timer_queue_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_now             (in_now),
    .in_interval_ms     (in_interval_ms),
    .in_handler_id      (in_handler_id),
    .in_argument        (in_argument),
    .in_slot            (in_slot),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_number    (out_slot_number),
    .out_fired_handler  (out_fired_handler),
    .out_fired_argument (out_fired_argument),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  // Bring the shadow pool to its reset state.
  function automatic void reset_pool();
    tick_rate = TPS_RESET;
    for (int i = 0; i < POOL; i++) begin
      expiry_tick[i]   = '0;
      slot_handler[i]  = '0;
      slot_argument[i] = '0;
      slot_link[i]     = (i + 1 < POOL) ? 4'(i + 1) : NIL;
    end
    armed_top = NIL;
    free_top  = 4'd0;
  endfunction

  function automatic timer_result_t make_result(input logic [STATUS_W-1:0] st,
                                                input logic [SLOT_W-1:0] sl,
                                                input logic [HANDLER_W-1:0] h,
                                                input logic [ARG_W-1:0] a,
                                                input logic lst);
    timer_result_t r;
    r.status         = st;
    r.slot_number    = sl;
    r.fired_handler  = h;
    r.fired_argument = a;
    r.last           = lst;
    return r;
  endfunction

  // Apply one accepted request to the shadow pool and queue its results.
  function automatic void predict_timer_request(input timer_word_t w);
    logic [63:0]       product;
    logic [TIME_W-1:0] expiry;
    logic [3:0]        s;
    logic [3:0]        prev;
    logic [3:0]        cur;
    int                fired;
    timer_result_t     r;
    product = {32'd0, w.interval_ms} * {47'd0, tick_rate};
    product = product / MS_PER_SECOND;
    expiry  = w.now + product[TIME_W-1:0];
    prev    = NIL;
    fired   = 0;
    case (w.kind)
      KIND_SET: begin
        if (free_top == NIL) begin
          pending_results.push_back(make_result(STS_POOL_FULL, '0, '0, '0, 1'b1));
        end else begin
          s = free_top;
          free_top = slot_link[s];
          expiry_tick[s]   = expiry;
          slot_handler[s]  = w.handler_id;
          slot_argument[s] = w.argument;
          // An equal expiry goes behind the entries already armed.
          cur = armed_top;
          while (cur != NIL && expiry_tick[cur] <= expiry) begin
            prev = cur;
            cur  = slot_link[cur];
          end
          slot_link[s] = cur;
          if (prev != NIL) slot_link[prev] = s;
          else armed_top = s;
          pending_results.push_back(make_result(STS_SET_OK, s[SLOT_W-1:0], '0, '0, 1'b1));
        end
      end
      KIND_CANCEL: begin
        cur = armed_top;
        while (cur != NIL && cur != {1'b0, w.slot}) begin
          prev = cur;
          cur  = slot_link[cur];
        end
        if (cur == NIL) begin
          pending_results.push_back(make_result(STS_NOT_ARMED, w.slot, '0, '0, 1'b1));
        end else begin
          if (prev != NIL) slot_link[prev] = slot_link[cur];
          else armed_top = slot_link[cur];
          slot_handler[cur] = '0;
          slot_link[cur]    = free_top;
          free_top          = cur;
          pending_results.push_back(make_result(STS_CANCELLED, cur[SLOT_W-1:0], '0, '0,
                                                1'b1));
        end
      end
      KIND_PROCESS: begin
        // Fire from the head while the head has expired, up to the fire limit.
        while (fired < MAX_FIRE && armed_top != NIL && w.now >= expiry_tick[armed_top]) begin
          s = armed_top;
          pending_results.push_back(make_result(STS_FIRED, s[SLOT_W-1:0], slot_handler[s],
                                                slot_argument[s], 1'b0));
          fired++;
          armed_top       = slot_link[s];
          slot_handler[s] = '0;
          slot_link[s]    = free_top;
          free_top        = s;
        end
        if (fired == 0) begin
          pending_results.push_back(make_result(STS_NOTHING, '0, '0, '0, 1'b1));
        end else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      default: begin
        // The unused kind is ignored and causes no result.
      end
    endcase
  endfunction

  // Compare one result word with the oldest expectation.
  task automatic check_result_word();
    timer_result_t e;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result word with nothing expected, status %0d slot %0d",
                                out_status, out_slot_number));
    end else begin
      e = pending_results.pop_front();
      if (out_status !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", out_status, e.status));
      if (out_slot_number !== e.slot_number)
        report_mismatch($sformatf("slot_number %0d, expected %0d", out_slot_number,
                                  e.slot_number));
      if (out_fired_handler !== e.fired_handler)
        report_mismatch($sformatf("fired_handler %0h, expected %0h", out_fired_handler,
                                  e.fired_handler));
      if (out_fired_argument !== e.fired_argument)
        report_mismatch($sformatf("fired_argument %0h, expected %0h", out_fired_argument,
                                  e.fired_argument));
      if (out_last !== e.last)
        report_mismatch($sformatf("last %0b, expected %0b", out_last, e.last));
    end
  endtask

  // Result check first, then prediction for a word accepted on this edge.
  always @(posedge clk) begin
    timer_word_t   w;
    timer_result_t r;
    if (rst_n) begin
      if (out_valid) check_result_word();
      if (start && !busy) begin
        w.kind        = in_kind;
        w.now         = in_now;
        w.interval_ms = in_interval_ms;
        w.handler_id  = in_handler_id;
        w.argument    = in_argument;
        w.slot        = in_slot;
        w.typed       = 1'b0;
        w.t_status    = '0;
        w.t_slot      = '0;
        predict_timer_request(w);
        if (typed_pending && pending_results.size() != 0) begin
          r = pending_results.pop_back();
          pending_results.push_back(make_result(typed_status, typed_slot, '0, '0, 1'b1));
        end
      end
    end
  end

  // Count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: end the run if the block stops moving.
  initial begin
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic timer_word_t script_row(input logic [KIND_W-1:0] k,
                                             input logic [TIME_W-1:0] nw,
                                             input logic [TIME_W-1:0] ms,
                                             input logic [HANDLER_W-1:0] h,
                                             input logic [ARG_W-1:0] a,
                                             input logic [SLOT_W-1:0] sl,
                                             input bit ty,
                                             input logic [STATUS_W-1:0] tst,
                                             input logic [SLOT_W-1:0] tsl);
    timer_word_t w;
    w.kind        = k;
    w.now         = nw;
    w.interval_ms = ms;
    w.handler_id  = h;
    w.argument    = a;
    w.slot        = sl;
    w.typed       = ty;
    w.t_status    = tst;
    w.t_slot      = tsl;
    return w;
  endfunction

  // Present one request word after an optional gap and wait until it is taken.
  task automatic send_word(input timer_word_t w, input int gap);
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind        = w.kind;
    in_now         = w.now;
    in_interval_ms = w.interval_ms;
    in_handler_id  = w.handler_id;
    in_argument    = w.argument;
    in_slot        = w.slot;
    typed_pending  = w.typed;
    typed_status   = w.t_status;
    typed_slot     = w.t_slot;
    start          = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write the tick rate once the block has gone quiet.
  task automatic write_tick_rate(input logic [TPS_W-1:0] rate);
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata = rate;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    tick_rate = rate;
  endtask

  // Stimulus
  initial begin
    timer_word_t      script [DIR_ROWS];
    logic [TPS_W-1:0] rates [PHASES];
    timer_word_t      w;
    logic [TIME_W-1:0] clock_now;
    logic [3:0]       armed_ids [POOL];
    logic [3:0]       cur;
    int               n_armed;
    int               pick;
    int               gap;
    bit               calm;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_kind        = '0;
    in_now         = '0;
    in_interval_ms = '0;
    in_handler_id  = '0;
    in_argument    = '0;
    in_slot        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    typed_pending  = 1'b0;
    typed_status   = '0;
    typed_slot     = '0;
    mismatches     = 0;
    reset_pool();

    // Directed rows: empty list, extremes, equal expiry, cancel, pool full.
    script[0]  = script_row(KIND_PROCESS, 32'd0, 32'd0, 8'd0, 16'd0, 3'd0,
                            1'b1, STS_NOTHING, 3'd0);
    script[1]  = script_row(KIND_CANCEL, 32'd0, 32'd0, 8'd0, 16'd0, 3'd0,
                            1'b1, STS_NOT_ARMED, 3'd0);
    script[2]  = script_row(KIND_CANCEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 3'd7,
                            1'b1, STS_NOT_ARMED, 3'd7);
    script[3]  = script_row(KIND_SET, 32'd0, 32'd0, 8'd0, 16'd0, 3'd0,
                            1'b1, STS_SET_OK, 3'd0);
    script[4]  = script_row(KIND_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 3'd7,
                            1'b1, STS_SET_OK, 3'd1);
    script[5]  = script_row(KIND_SET, 32'd100, 32'd1000, 8'd5, 16'd1234, 3'd0,
                            1'b1, STS_SET_OK, 3'd2);
    script[6]  = script_row(KIND_SET, 32'd100, 32'd1000, 8'd6, 16'd4321, 3'd0,
                            1'b1, STS_SET_OK, 3'd3);
    script[7]  = script_row(KIND_SET, 32'd0, 32'd0, 8'd7, 16'd77, 3'd0,
                            1'b1, STS_SET_OK, 3'd4);
    script[8]  = script_row(KIND_CANCEL, 32'd0, 32'd0, 8'd0, 16'd0, 3'd3,
                            1'b1, STS_CANCELLED, 3'd3);
    script[9]  = script_row(KIND_CANCEL, 32'd0, 32'd0, 8'd0, 16'd0, 3'd3,
                            1'b1, STS_NOT_ARMED, 3'd3);
    script[10] = script_row(KIND_PROCESS, 32'd0, 32'd0, 8'd0, 16'd0, 3'd0, 1'b0, '0, '0);
    script[11] = script_row(KIND_PROCESS, 32'd32868, 32'd0, 8'd0, 16'd0, 3'd0, 1'b0, '0, '0);
    script[12] = script_row(KIND_SET, 32'd1000, 32'd0, 8'h80, 16'h8000, 3'd0, 1'b0, '0, '0);
    script[13] = script_row(KIND_SET, 32'd1000, 32'd1, 8'h01, 16'h0001, 3'd0, 1'b0, '0, '0);
    script[14] = script_row(KIND_SET, 32'd1000, 32'd999, 8'h3C, 16'h00FF, 3'd0, 1'b0, '0, '0);
    script[15] = script_row(KIND_SET, 32'd1000, 32'd1000, 8'h00, 16'hFF00, 3'd0, 1'b0, '0, '0);
    script[16] = script_row(KIND_SET, 32'd2000, 32'd5, 8'hA5, 16'h5A5A, 3'd0, 1'b0, '0, '0);
    script[17] = script_row(KIND_SET, 32'd2000, 32'd2000, 8'h5A, 16'hA5A5, 3'd0, 1'b0, '0, '0);
    script[18] = script_row(KIND_SET, 32'd3000, 32'h8000_0000, 8'hFE, 16'h7FFF, 3'd0,
                            1'b0, '0, '0);
    script[19] = script_row(KIND_SET, 32'd3000, 32'd10, 8'h11, 16'h1111, 3'd0,
                            1'b1, STS_POOL_FULL, 3'd0);
    script[20] = script_row(KIND_CANCEL, 32'd0, 32'd0, 8'd0, 16'd0, 3'd5,
                            1'b1, STS_CANCELLED, 3'd5);
    script[21] = script_row(2'd3, 32'h1234_5678, 32'h8765_4321, 8'h99, 16'h9999, 3'd6,
                            1'b0, '0, '0);
    script[22] = script_row(KIND_PROCESS, 32'hFFFF_FFFF, 32'd0, 8'd0, 16'd0, 3'd0,
                            1'b0, '0, '0);
    script[23] = script_row(KIND_PROCESS, 32'd0, 32'd0, 8'd0, 16'd0, 3'd0,
                            1'b1, STS_NOTHING, 3'd0);

    rates[0] = 17'd1;
    rates[1] = 17'd65536;
    rates[2] = 17'd1000;
    rates[3] = 17'h1FFFF;
    rates[4] = 17'd0;
    rates[5] = 17'($urandom_range(1, 65536));
    rates[6] = TPS_RESET;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset tick rate
    for (int i = 0; i < DIR_ROWS; i++) begin
      gap = ($urandom_range(0, 99) < 13) ? $urandom_range(1, 4) : 0;
      send_word(script[i], gap);
    end

    // Random part, one phase per tick rate
    for (int p = 0; p < PHASES; p++) begin
      write_tick_rate(rates[p]);
      clock_now = (p == 3) ? 32'hFFFF_0000 : $urandom;
      calm = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        clock_now += $urandom_range(0, 3000);
        pick = $urandom_range(0, 99);
        if (pick < 40) w.kind = KIND_SET;
        else if (pick < 68) w.kind = KIND_PROCESS;
        else if (pick < 94) w.kind = KIND_CANCEL;
        else w.kind = 2'd3;
        w.now         = ($urandom_range(0, 9) == 0) ? $urandom : clock_now;
        w.interval_ms = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 100);
        w.handler_id  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
        w.argument    = 16'($urandom);
        w.slot        = 3'($urandom);
        w.typed       = 1'b0;
        w.t_status    = '0;
        w.t_slot      = '0;
        // Most cancels name a slot that is armed right now.
        if (w.kind == KIND_CANCEL && $urandom_range(0, 99) < 75) begin
          n_armed = 0;
          cur = armed_top;
          while (cur != NIL) begin
            armed_ids[n_armed] = cur;
            n_armed++;
            cur = slot_link[cur];
          end
          if (n_armed != 0) w.slot = armed_ids[$urandom_range(0, n_armed - 1)][SLOT_W-1:0];
        end
        gap = (!calm && $urandom_range(0, 99) < 13) ? $urandom_range(1, 4) : 0;
        send_word(w, gap);
      end
    end

    @(negedge clk);
    start = 1'b0;
    typed_pending = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/stq_pkg.sv
sv/stq_ram.sv
sv/sorted_timer_queue_top.sv
tb/sv/tb.sv
